FILE: rtl/lmcd_pkg.sv
// Shared types and constants for the LFO-modulated chorus/flanger delay.
// Holds the sample type, register indexes and the quarter-wave sine table builder.
// No dependencies.
package lmcd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int SINE_BITS    = 10;
  localparam int QUARTER      = 1 << (SINE_BITS - 2);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [14:0] sine_rom_t [0:QUARTER];

  typedef enum logic [2:0] {
    REG_BASE_DELAY      = 3'd0,
    REG_FEEDBACK_GAIN   = 3'd1,
    REG_FORWARD_GAIN    = 3'd2,
    REG_MIX_GAIN        = 3'd3,
    REG_SWEEP_DEPTH     = 3'd4,
    REG_PHASE_INCREMENT = 3'd5,
    REG_START_PHASE     = 3'd6,
    REG_FEEDBACK_MODE   = 3'd7
  } reg_idx_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  // Reciprocal of six scaled by 2^32, rounded up; exact for operands below 2^31.
  localparam logic [31:0] RECIP_SIX = 32'd715827883;

  // Shift-and-subtract unsigned division, used only while building the table.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine magnitude in Q0.15, one entry per table step from 0 to pi/2.
  // Evaluated at elaboration only.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned r, x, x2, t, s, v, den;
    for (int j = 0; j <= QUARTER; j++) begin
      r  = longint'(j) << (32 - SINE_BITS);
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int n = 0; n < 5; n++) begin
        case (n)
          0: den = 110;
          1: den = 72;
          2: den = 42;
          3: den = 20;
          default: den = 6;
        endcase
        t = ONE_Q30 - div_u64((x2 * t) >> 30, den);
      end
      s = (x * t) >> 30;
      v = (s + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      rom[j] = v[14:0];
    end
    return rom;
  endfunction

endpackage

FILE: rtl/lmcd_sample_if.sv
// Valid/ready sample channel used for the audio input and output.
// Depends on lmcd_pkg for the sample type.
interface lmcd_sample_if import lmcd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lfo_modulated_chorus_delay.sv
// One request at a time: a new sample is taken only once the previous result has been
// loaded into the output register. Feedback comes from the modulated tap, or, with a
// second pass, from the fixed tap; all products go through the single shared multiplier.
// A stalled output register adds its stall before the next request is taken.
// Reset is synchronous: registers take their defaults, then a clearing pass zeroes
// every entry of the delay line before the first request is taken.
// Depends on lmcd_pkg and lmcd_sample_if.
module lfo_modulated_chorus_delay import lmcd_pkg::*; #(
  parameter int DELAY_DEPTH = 1024,
  parameter int MIN_DELAY   = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  lmcd_sample_if.sink        sample_in,
  lmcd_sample_if.source      sample_out
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int DLY_W = (AW + 9 > 20) ? AW + 9 : 20;
  localparam logic [DLY_W-1:0] DLY_MIN   = DLY_W'(MIN_DELAY * 256);
  localparam logic [DLY_W-1:0] DLY_MAX   = DLY_W'((DELAY_DEPTH - MIN_DELAY) * 256);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic [AW+1:0]    DEPTH_EXT = (AW + 2)'(DELAY_DEPTH);
  localparam sine_rom_t        SINE_ROM  = build_sine_rom();
  localparam logic signed [47:0] LAGR_HALF = 48'sd50331648;
  localparam logic signed [26:0] U_OFFSET  = 27'sd25165824;
  localparam logic signed [24:0] V_OFFSET  = 25'sd4194304;
  localparam logic signed [45:0] SAT_HI    = 46'sd32767;
  localparam logic signed [45:0] SAT_LO    = -46'sd32768;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SINE, S_SWEEP, S_DELAY, S_INTERP, S_GAIN
  } state_t;

  // Configuration registers
  logic [17:0]        base_delay;
  logic signed [15:0] feedback_gain;
  logic signed [15:0] forward_gain;
  logic signed [15:0] mix_gain;
  logic [16:0]        sweep_depth;
  logic [31:0]        phase_increment;
  logic [31:0]        start_phase;
  logic               feedback_mode;

  // Sequencer and datapath
  state_t             state;
  logic [3:0]         step;
  logic               fixed_pass;
  logic [31:0]        lfo_phase;
  logic [AW-1:0]      write_pointer;
  logic [AW-1:0]      clr_cnt;
  sample_t            xin;
  logic [16:0]        sine_ofs;
  logic [AW-1:0]      tap_int;
  logic [7:0]         frac;
  logic signed [31:0] ab;
  logic signed [31:0] w0, w1, w2, w3;
  sample_t            tap0, tap1, tap2, tap3;
  logic signed [47:0] acc;
  logic [25:0]        u_val;
  logic signed [23:0] mod_tap;
  logic signed [23:0] fb_tap;
  sample_t            x1;
  logic signed [44:0] mix_term;
  logic               out_valid;
  sample_t            out_data;
  logic               res_load;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [58:0] prod;

  // Delay line
  sample_t            mem [DELAY_DEPTH];
  sample_t            rd;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  sample_t            mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  function automatic sample_t sat_sample(input logic signed [45:0] v);
    sample_t r;
    if (v > SAT_HI) r = sample_t'(SAT_HI);
    else if (v < SAT_LO) r = sample_t'(SAT_LO);
    else r = v[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_BASE_DELAY:      prdata = {14'd0, base_delay};
      REG_FEEDBACK_GAIN:   prdata = {{16{feedback_gain[15]}}, feedback_gain};
      REG_FORWARD_GAIN:    prdata = {{16{forward_gain[15]}}, forward_gain};
      REG_MIX_GAIN:        prdata = {{16{mix_gain[15]}}, mix_gain};
      REG_SWEEP_DEPTH:     prdata = {15'd0, sweep_depth};
      REG_PHASE_INCREMENT: prdata = phase_increment;
      REG_START_PHASE:     prdata = start_phase;
      REG_FEEDBACK_MODE:   prdata = {31'd0, feedback_mode};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay      <= 18'd5120;
      feedback_gain   <= 16'sd8192;
      forward_gain    <= 16'sd16384;
      mix_gain        <= 16'sd16384;
      sweep_depth     <= 17'd512;
      phase_increment <= 32'd4473924;
      start_phase     <= 32'd1073741824;
      feedback_mode   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_DELAY:      base_delay      <= pwdata[17:0];
        REG_FEEDBACK_GAIN:   feedback_gain   <= pwdata[15:0];
        REG_FORWARD_GAIN:    forward_gain    <= pwdata[15:0];
        REG_MIX_GAIN:        mix_gain        <= pwdata[15:0];
        REG_SWEEP_DEPTH:     sweep_depth     <= pwdata[16:0];
        REG_PHASE_INCREMENT: phase_increment <= pwdata;
        REG_START_PHASE:     start_phase     <= pwdata;
        REG_FEEDBACK_MODE:   feedback_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Sine lookup: round the phase to a table step, fold into the first quadrant.
  logic [31:0]          k_raw;
  logic [SINE_BITS-1:0] k_idx;
  logic [SINE_BITS-3:0] k_low;
  logic [SINE_BITS-2:0] rom_idx;
  logic [14:0]          sine_mag;
  logic [16:0]          sine_ofs_next;

  always_comb begin
    k_raw    = lfo_phase + (32'd1 << (31 - SINE_BITS));
    k_idx    = k_raw[31 -: SINE_BITS];
    k_low    = k_idx[SINE_BITS-3:0];
    rom_idx  = k_idx[SINE_BITS-2] ? ((SINE_BITS-1)'(QUARTER) - {1'b0, k_low})
                                  : {1'b0, k_low};
    sine_mag = SINE_ROM[rom_idx];
    sine_ofs_next = k_idx[SINE_BITS-1] ? (17'd32768 - {2'd0, sine_mag})
                                       : (17'd32768 + {2'd0, sine_mag});
  end

  // Tap delay in Q.8, clamped to the usable part of the line.
  logic [DLY_W-1:0] dly_raw;
  logic [DLY_W-1:0] dly_lo;
  logic [DLY_W-1:0] dly_cl;

  always_comb begin
    if (fixed_pass)
      dly_raw = DLY_W'(base_delay) + DLY_MIN;
    else
      dly_raw = DLY_W'(base_delay) + DLY_W'(prod[33:15]) + DLY_MIN;
    dly_lo = (dly_raw < DLY_MIN) ? DLY_MIN : dly_raw;
    dly_cl = (dly_lo > DLY_MAX) ? DLY_MAX : dly_lo;
  end

  // Lagrange node offsets from the fraction.
  logic signed [10:0] a_f, b_f, c_f;
  assign a_f = $signed({3'd0, frac}) - 11'sd256;
  assign b_f = $signed({3'd0, frac}) - 11'sd512;
  assign c_f = $signed({3'd0, frac}) - 11'sd768;

  // Read address of the neighbouring tap for the current step.
  logic [1:0]         rd_k;
  logic signed [AW+1:0] rd_diff;

  always_comb begin
    rd_k      = 2'(step - 4'd2);
    rd_diff   = $signed({2'd0, write_pointer}) - $signed({2'd0, tap_int})
                - $signed({{AW{1'b0}}, rd_k});
    mem_raddr = rd_diff[AW+1] ? AW'(rd_diff + $signed(DEPTH_EXT)) : rd_diff[AW-1:0];
  end

  // Post-multiply rounding terms.
  logic signed [58:0] g_rnd;
  logic signed [44:0] g_term;
  logic signed [47:0] lag_sum;
  logic signed [26:0] u_sum;
  logic signed [24:0] v_res;
  sample_t            x1_next;
  sample_t            y_next;

  always_comb begin
    g_rnd   = prod + 59'sd8192;
    g_term  = g_rnd[58:14];
    lag_sum = acc + prod[47:0] + LAGR_HALF;
    u_sum   = $signed({{3{lag_sum[47]}}, lag_sum[47:24]}) + U_OFFSET;
    v_res   = $signed({1'b0, prod[55:32]}) - V_OFFSET;
    x1_next = sat_sample(46'(xin) + 46'(g_term));
    y_next  = sat_sample(46'(mix_term) + 46'(g_term));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SWEEP: begin
        mul_a = $signed({15'd0, sweep_depth});
        mul_b = $signed({10'd0, sine_ofs});
      end
      S_INTERP: begin
        case (step)
          4'd0: begin mul_a = 32'(a_f);         mul_b = 27'(b_f); end
          4'd1: begin mul_a = prod[31:0];       mul_b = 27'(c_f); end
          4'd2: begin mul_a = ab;               mul_b = $signed({19'd0, frac}); end
          4'd3: begin mul_a = $signed({24'd0, frac}); mul_b = 27'(c_f); end
          4'd4: begin mul_a = prod[31:0];       mul_b = 27'(b_f) * 27'sd3; end
          4'd5: begin mul_a = ab;               mul_b = 27'(a_f) * -27'sd3; end
          4'd6: begin mul_a = w0;               mul_b = 27'(tap0); end
          4'd7: begin mul_a = w1;               mul_b = 27'(tap1); end
          4'd8: begin mul_a = w2;               mul_b = 27'(tap2); end
          4'd9: begin mul_a = w3;               mul_b = 27'(tap3); end
          4'd11: begin mul_a = $signed(RECIP_SIX); mul_b = $signed({1'b0, u_val}); end
          default: ;
        endcase
      end
      S_GAIN: begin
        case (step)
          4'd0: begin mul_a = 32'(fb_tap);  mul_b = 27'(feedback_gain); end
          4'd1: begin mul_a = 32'(x1_next); mul_b = 27'(mix_gain); end
          // The forward product is recomputed while the result waits.
          4'd2, 4'd3: begin mul_a = 32'(mod_tap); mul_b = 27'(forward_gain); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 59'(mul_a * mul_b);
  end

  // Delay line port control
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_GAIN && step == 4'd2);
    mem_waddr = (state == S_CLEAR) ? clr_cnt : write_pointer;
    mem_wdata = (state == S_CLEAR) ? sample_t'(0) : x1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd <= mem[mem_raddr];
  end

  assign sample_in.ready  = (state == S_IDLE);
  assign sample_out.valid = out_valid;
  assign sample_out.data  = out_data;
  assign res_load = (state == S_GAIN) && (step == 4'd3) && (!out_valid || sample_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      step          <= 4'd0;
      fixed_pass    <= 1'b0;
      clr_cnt       <= '0;
      write_pointer <= LAST_ADDR;
      lfo_phase     <= 32'd1073741824;
      out_valid     <= 1'b0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (out_valid && sample_out.ready) out_valid <= 1'b0;
      // Writing the start phase also resyncs the LFO.
      if (cfg_wr && cfg_idx == REG_START_PHASE) lfo_phase <= pwdata;
      else if (state == S_IDLE && sample_in.valid) lfo_phase <= lfo_phase + phase_increment;

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) state <= S_IDLE;
        end
        S_IDLE: begin
          if (sample_in.valid) begin
            xin        <= sample_in.data;
            fixed_pass <= 1'b0;
            state      <= S_SINE;
          end
        end
        S_SINE: begin
          sine_ofs <= sine_ofs_next;
          state    <= S_SWEEP;
        end
        S_SWEEP: begin
          state <= S_DELAY;
        end
        S_DELAY: begin
          tap_int <= dly_cl[AW+7:8];
          frac    <= dly_cl[7:0];
          step    <= 4'd0;
          state   <= S_INTERP;
        end
        S_INTERP: begin
          step <= (step == 4'd12) ? 4'd0 : step + 4'd1;
          case (step)
            4'd1: ab <= prod[31:0];
            4'd2: w0 <= -prod[31:0];
            4'd3: w3 <= prod[31:0];
            4'd4: ab <= prod[31:0];
            4'd5: w1 <= prod[31:0];
            4'd6: w2 <= prod[31:0];
            4'd7: acc <= prod[47:0];
            4'd8, 4'd9: acc <= acc + prod[47:0];
            4'd10: u_val <= u_sum[25:0];
            4'd12: begin
              if (fixed_pass) begin
                fb_tap <= v_res[23:0];
                state  <= S_GAIN;
              end else begin
                mod_tap <= v_res[23:0];
                if (feedback_mode) begin
                  fixed_pass <= 1'b1;
                  state      <= S_DELAY;
                end else begin
                  fb_tap <= v_res[23:0];
                  state  <= S_GAIN;
                end
              end
            end
            default: ;
          endcase
          // Tap reads issued at steps two to five are captured from the registered read port.
          case (step)
            4'd3: tap0 <= rd;
            4'd4: tap1 <= rd;
            4'd5: tap2 <= rd;
            4'd6: tap3 <= rd;
            default: ;
          endcase
        end
        S_GAIN: begin
          case (step)
            4'd0: step <= 4'd1;
            4'd1: begin
              x1   <= x1_next;
              step <= 4'd2;
            end
            4'd2: begin
              mix_term <= g_term;
              step     <= 4'd3;
            end
            default: begin
              // Hold the last product until the output register is free.
              if (res_load) begin
                out_data      <= y_next;
                write_pointer <= (write_pointer == LAST_ADDR) ? '0 : write_pointer + 1'b1;
                step          <= 4'd0;
                state         <= S_IDLE;
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
    else $error("request taken while a sample is still in work");

  a_wp_moves_at_finish: assert property (@(posedge clk) disable iff (rst)
    !$stable(write_pointer) |-> $past(state == S_GAIN))
    else $error("write pointer moved outside the gain stage");

  a_result_from_gain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_GAIN))
    else $error("result presented without finishing the gain stage");
`endif

endmodule
